// ----- design/dst_pkg.sv -----
// Shared constants, sine-table arithmetic constants and handoff type for the sine transform.
package dst_pkg;

	localparam int LENGTH_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int SINE_BITS_DEF = 16;
	localparam int COEF_BITS = 22;

	// Pi and one in Q30, used when the sine table is built.
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	// Divisors (2i)(2i+1) of the Taylor terms for i = 1..7.
	localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210};

	// Accumulator handoff from the MAC engine to the scaler.
	typedef struct packed {
		logic valid;
		logic last;
	} hand_t;

endpackage

// ----- design/direct_sine_transform_top.sv -----
// Top level of the Type-I discrete sine transform with a shared MAC engine.
//
// Input words arrive on start/sample/last_sample and are taken at a clock edge where
// start is high and busy is low. A block closes on last_sample or after LENGTH words;
// missing positions of a short block count as zero. Each closed block produces LENGTH
// coefficient words, each shown for one cycle with done high; last_coefficient marks
// the final one. The receiver cannot stall, so results are never held back.
// Samples go into one of two banks, so a new block loads while the previous one is
// being transformed; busy rises only when both banks are taken.
// The MAC pipeline does one MAC per cycle while the scaler takes its sums, and holds
// while a finished sum waits for the scaler. For each coefficient the scaler passes
// through ST_FIN, after ST_MUL and ST_COR in inverse mode, and sets the pace for short
// blocks. inverse_mode must be written through config_write/config_data only while
// the block is idle; the block itself does not enforce it. Reset clears the control
// state and inverse_mode; the sample banks are not cleared and need no clearing pass.
module direct_sine_transform_top #(
	parameter int LENGTH = dst_pkg::LENGTH_DEF,
	parameter int SAMPLE_BITS = dst_pkg::SAMPLE_BITS_DEF,
	parameter int SINE_BITS = dst_pkg::SINE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic                                 last_sample,
	output logic                                 done,
	output logic signed [dst_pkg::COEF_BITS-1:0] coefficient,
	output logic                                 last_coefficient,
	input  logic                                 config_write,
	input  logic                                 config_data
);

	localparam int AW = (LENGTH > 1) ? $clog2(LENGTH) : 1;
	localparam int CNT_BITS = $clog2(LENGTH + 1);
	localparam int ACC_RAW = SAMPLE_BITS + SINE_BITS + $clog2(LENGTH + 1);
	localparam int ACC_BITS = (ACC_RAW > 64) ? 64 : ACC_RAW;

	logic                   inverse_q;
	logic                   wr_en;
	logic [AW:0]            wr_addr;
	logic [SAMPLE_BITS-1:0] wr_data;
	logic                   push;
	logic [CNT_BITS:0]      job_in;
	logic [CNT_BITS:0]      job_out;
	logic                   pop;
	logic [1:0]             q_count;
	logic                   back_active;
	logic                   ready;
	dst_pkg::hand_t         hand;
	logic [ACC_BITS-1:0]    acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
		end else if (config_write) begin
			inverse_q <= config_data;
		end
	end

	// Each queued job and the job in the MAC engine each hold one bank.
	assign busy = (3'(q_count) + 3'(back_active)) == 3'd2;

	dst_front #(
		.LENGTH(LENGTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.last_sample(last_sample),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.push(push),
		.job(job_in)
	);

	dst_queue #(
		.DATA_BITS(CNT_BITS + 1)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(job_in),
		.pop(pop),
		.dout(job_out),
		.count(q_count)
	);

	dst_back #(
		.LENGTH(LENGTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.SINE_BITS(SINE_BITS),
		.ACC_BITS(ACC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_valid(q_count != 2'd0),
		.job(job_out),
		.pop(pop),
		.active(back_active),
		.ready(ready),
		.hand(hand),
		.acc(acc)
	);

	dst_scale #(
		.LENGTH(LENGTH),
		.SINE_BITS(SINE_BITS),
		.ACC_BITS(ACC_BITS)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.inverse(inverse_q),
		.hand(hand),
		.acc(acc),
		.ready(ready),
		.done(done),
		.coefficient(coefficient),
		.last_coefficient(last_coefficient)
	);

	// The scaler returns to idle after each word, so results never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result words on consecutive cycles");

	// An accepted word never finds the job queue full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> (q_count != 2'd2))
		else $error("word accepted while both banks are taken");

	// A finished sum that the scaler cannot take yet holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hand.valid && !ready) |=> (hand.valid && $stable(acc) && $stable(hand.last)))
		else $error("stalled accumulator handoff changed");

endmodule

// ----- design/dst_front.sv -----
// Input side: takes samples, writes them into the current bank and closes blocks.
module dst_front #(
	parameter int LENGTH = dst_pkg::LENGTH_DEF,
	parameter int SAMPLE_BITS = dst_pkg::SAMPLE_BITS_DEF,
	localparam int AW = (LENGTH > 1) ? $clog2(LENGTH) : 1,
	localparam int CNT_BITS = $clog2(LENGTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   last_sample,
	output logic                   wr_en,
	output logic [AW:0]            wr_addr,
	output logic [SAMPLE_BITS-1:0] wr_data,
	output logic                   push,
	output logic [CNT_BITS:0]      job
);

	logic [AW-1:0] idx_q;
	logic          bank_q;
	logic          accept;
	logic          close;

	assign accept = start & ~busy;
	// A block closes on the flagged sample or when the bank is full.
	assign close = last_sample | (idx_q == AW'(LENGTH - 1));

	assign wr_en = accept;
	assign wr_addr = {bank_q, idx_q};
	assign wr_data = sample;
	assign push = accept & close;
	assign job = {bank_q, CNT_BITS'(idx_q) + CNT_BITS'(1)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (close) begin
				idx_q <= '0;
				bank_q <= ~bank_q;
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

endmodule

// ----- design/dst_queue.sv -----
// Two-entry job queue between the input side and the MAC engine.
module dst_queue #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [DATA_BITS-1:0] din,
	input  logic                 pop,
	output logic [DATA_BITS-1:0] dout,
	output logic [1:0]           count
);

	logic [DATA_BITS-1:0] slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;

	assign dout = slot_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/dst_back.sv -----
// MAC engine: sample memory, sine table and one shared multiply-accumulate pipeline.
module dst_back #(
	parameter int LENGTH = dst_pkg::LENGTH_DEF,
	parameter int SAMPLE_BITS = dst_pkg::SAMPLE_BITS_DEF,
	parameter int SINE_BITS = dst_pkg::SINE_BITS_DEF,
	parameter int ACC_BITS = 39,
	localparam int AW = (LENGTH > 1) ? $clog2(LENGTH) : 1,
	localparam int CNT_BITS = $clog2(LENGTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [AW:0]            wr_addr,
	input  logic [SAMPLE_BITS-1:0] wr_data,
	input  logic                   job_valid,
	input  logic [CNT_BITS:0]      job,
	output logic                   pop,
	output logic                   active,
	input  logic                   ready,
	output dst_pkg::hand_t         hand,
	output logic [ACC_BITS-1:0]    acc
);

	localparam int P = LENGTH + 1;
	localparam int QN = P / 2 + 1;
	localparam int IDX_BITS = $clog2(QN);
	localparam int M_BITS = $clog2(4 * P);
	localparam int MAG_BITS = SINE_BITS - 1;
	localparam int PROD_BITS = SAMPLE_BITS + SINE_BITS;
	localparam logic [63:0] P64 = 64'(P);
	localparam logic [M_BITS-1:0] MP = M_BITS'(P);
	localparam logic [M_BITS-1:0] M2P = M_BITS'(2 * P);

	// Magnitude of sin(pi*m/P) for m in the first quadrant, Taylor series in Q30.
	function automatic logic [MAG_BITS-1:0] sine_mag(input int unsigned m);
		logic [63:0] theta;
		logic [63:0] term;
		logic [63:0] sum_pos;
		logic [63:0] sum_neg;
		logic [63:0] s;
		theta = (dst_pkg::PI_Q30 * 64'(m) + (P64 >> 1)) / P64;
		term = theta;
		sum_pos = theta;
		sum_neg = 64'd0;
		for (int i = 0; i < 7; i++) begin
			term = (term * theta) >> 30;
			term = (term * theta) >> 30;
			term = term / dst_pkg::TAYLOR_DIV[i];
			if (i[0] == 1'b0) begin
				sum_neg = sum_neg + term;
			end else begin
				sum_pos = sum_pos + term;
			end
		end
		s = (sum_pos > sum_neg) ? sum_pos - sum_neg : 64'd0;
		if (s > dst_pkg::ONE_Q30) begin
			s = dst_pkg::ONE_Q30;
		end
		s = (s + (64'd1 << (30 - SINE_BITS))) >> (31 - SINE_BITS);
		if (s > (64'd1 << MAG_BITS) - 64'd1) begin
			s = (64'd1 << MAG_BITS) - 64'd1;
		end
		return s[MAG_BITS-1:0];
	endfunction

	logic [MAG_BITS-1:0] sine_tab [QN];

	for (genvar g = 0; g < QN; g++) begin : g_tab
		localparam logic [MAG_BITS-1:0] VAL = sine_mag(g);
		assign sine_tab[g] = VAL;
	end

	logic [SAMPLE_BITS-1:0] mem [2 ** (AW + 1)];

	// Issue sequencer state.
	logic                active_q;
	logic                bank_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [AW-1:0]       n_q;
	logic [AW-1:0]       k_q;
	logic [M_BITS-1:0]   step_q;
	logic [M_BITS-1:0]   m_q;

	logic                en;
	logic                issue;
	logic                last_n;
	logic                last_k;
	logic [M_BITS-1:0]   m_add;
	logic [M_BITS-1:0]   m_next;
	logic                neg;
	logic [M_BITS-1:0]   m1;
	logic [M_BITS-1:0]   m2;

	logic                          valid_s1, valid_s2, valid_s3;
	logic                          first_s1, first_s2, first_s3;
	logic                          last_s1, last_s2, last_s3;
	logic                          lastk_s1, lastk_s2, lastk_s3;
	logic [IDX_BITS-1:0]           idx_s1;
	logic                          neg_s1;
	logic [SAMPLE_BITS-1:0]        rd_s1;
	logic signed [SAMPLE_BITS-1:0] samp_s2;
	logic signed [SINE_BITS-1:0]   sine_s2;
	logic signed [PROD_BITS-1:0]   prod_s3;
	logic [ACC_BITS-1:0]           acc_q;
	logic [ACC_BITS-1:0]           acc_sum;

	assign hand.valid = valid_s3 & last_s3;
	assign hand.last = lastk_s3;
	// The whole pipeline holds while a finished sum waits for the scaler.
	assign en = ~(hand.valid & ~ready);
	assign issue = active_q & en;
	assign pop = ~active_q & job_valid;
	assign active = active_q;

	assign last_n = (CNT_BITS'(n_q) + CNT_BITS'(1)) == cnt_q;
	assign last_k = k_q == AW'(LENGTH - 1);

	// The phase (n+1)(k+1) mod 2P advances by k+1 for each sample.
	assign m_add = m_q + step_q;
	assign m_next = (m_add >= M2P) ? m_add - M2P : m_add;

	// Fold the phase into the first quadrant; the second half turn flips the sign.
	assign neg = m_q >= MP;
	assign m1 = neg ? m_q - MP : m_q;
	assign m2 = ((m1 << 1) > MP) ? MP - m1 : m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bank_q <= 1'b0;
			cnt_q <= '0;
			n_q <= '0;
			k_q <= '0;
			step_q <= '0;
			m_q <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			bank_q <= job[CNT_BITS];
			cnt_q <= job[CNT_BITS-1:0];
			n_q <= '0;
			k_q <= '0;
			step_q <= M_BITS'(1);
			m_q <= M_BITS'(1);
		end else if (issue) begin
			if (last_n) begin
				if (last_k) begin
					active_q <= 1'b0;
				end else begin
					k_q <= k_q + AW'(1);
					n_q <= '0;
					step_q <= step_q + M_BITS'(1);
					m_q <= step_q + M_BITS'(1);
				end
			end else begin
				n_q <= n_q + AW'(1);
				m_q <= m_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			rd_s1 <= mem[{bank_q, n_q}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_s1 <= n_q == '0;
			last_s1 <= last_n;
			lastk_s1 <= last_k;
			idx_s1 <= m2[IDX_BITS-1:0];
			neg_s1 <= neg;

			first_s2 <= first_s1;
			last_s2 <= last_s1;
			lastk_s2 <= lastk_s1;
			samp_s2 <= rd_s1;
			sine_s2 <= neg_s1 ? -$signed({1'b0, sine_tab[idx_s1]})
				: $signed({1'b0, sine_tab[idx_s1]});

			first_s3 <= first_s2;
			last_s3 <= last_s2;
			lastk_s3 <= lastk_s2;
			prod_s3 <= samp_s2 * sine_s2;

			if (valid_s3 && !last_s3) begin
				acc_q <= acc_sum;
			end
		end
	end

	assign acc_sum = (first_s3 ? '0 : acc_q) + ACC_BITS'(prod_s3);
	assign acc = acc_sum;

endmodule

// ----- design/dst_scale.sv -----
// Scaler: rounds, optionally divides by (LENGTH+1)/2 through a reciprocal product, saturates and emits.
module dst_scale #(
	parameter int LENGTH = dst_pkg::LENGTH_DEF,
	parameter int SINE_BITS = dst_pkg::SINE_BITS_DEF,
	parameter int ACC_BITS = 39
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                inverse,
	input  dst_pkg::hand_t                      hand,
	input  logic [ACC_BITS-1:0]                 acc,
	output logic                                ready,
	output logic                                done,
	output logic signed [dst_pkg::COEF_BITS-1:0] coefficient,
	output logic                                last_coefficient
);

	localparam int CB = dst_pkg::COEF_BITS;
	localparam int P = LENGTH + 1;
	localparam int NUM_BITS = (ACC_BITS + 1 > 64) ? 64 : ACC_BITS + 1;
	localparam int SH = SINE_BITS - 1;
	localparam int HI_BITS = NUM_BITS - SH;
	localparam int PRD_BITS = 2 * HI_BITS;
	localparam int R_BITS = $clog2(P);
	localparam int RND_W = R_BITS + SINE_BITS;
	localparam int W = (HI_BITS + 1 > CB + 1) ? HI_BITS + 1 : CB + 1;
	localparam logic [RND_W-1:0] DEN_RND = RND_W'(P) << SH;
	localparam logic [HI_BITS-1:0] P_HI = HI_BITS'(P);
	localparam logic [HI_BITS-1:0] RECIP = HI_BITS'((64'd1 << HI_BITS) / 64'(P));
	localparam logic [W-1:0] LIM_POS = W'((1 << (CB - 1)) - 1);
	localparam logic [W-1:0] LIM_NEG = W'(1 << (CB - 1));

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_COR = 2'd2;
	localparam logic [1:0] ST_FIN = 2'd3;

	logic [1:0]          state_q;
	logic [HI_BITS-1:0]  hi_q;
	logic [HI_BITS-1:0]  q_q;
	logic [SH-1:0]       lo_q;
	logic [R_BITS-1:0]   r_q;
	logic                neg_q;
	logic                last_q;
	logic                inv_q;
	logic                done_q;
	logic [CB-1:0]       coef_q;
	logic                lastc_q;

	logic                load;
	logic [ACC_BITS-1:0] mag;
	logic [NUM_BITS-1:0] num;
	logic [PRD_BITS-1:0] prod;
	logic [HI_BITS-1:0]  qp;
	logic [HI_BITS-1:0]  rem;
	logic                ge;
	logic                rnd;
	logic [W-1:0]        qf;
	logic [W-1:0]        mq;
	logic [CB-1:0]       coef_d;

	assign ready = state_q == ST_IDLE;
	assign load = hand.valid & ready;
	assign mag = acc[ACC_BITS-1] ? ACC_BITS'(0) - acc : acc;
	assign num = inverse ? NUM_BITS'({mag, 1'b0}) : NUM_BITS'(mag);

	// The reciprocal product gives the quotient by P or one less; one compare and
	// subtract on the remainder settles it.
	assign prod = hi_q * RECIP;
	assign qp = q_q * P_HI;
	assign rem = hi_q - qp;
	assign ge = rem >= P_HI;

	// Round half away from zero: the remainder is compared with half the divisor.
	assign rnd = inv_q ? ({r_q, lo_q, 1'b0} >= DEN_RND) : lo_q[SH-1];
	assign qf = W'(hi_q) + W'(rnd);
	assign mq = (qf > LIM_NEG) ? LIM_NEG : qf;
	assign coef_d = neg_q ? CB'(W'(0) - mq) : CB'((qf > LIM_POS) ? LIM_POS : qf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= state_q == ST_FIN;
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= inverse ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL: begin
					state_q <= ST_COR;
				end
				ST_COR: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hi_q <= num[NUM_BITS-1:SH];
			lo_q <= num[SH-1:0];
			r_q <= '0;
			neg_q <= acc[ACC_BITS-1];
			last_q <= hand.last;
			inv_q <= inverse;
		end else if (state_q == ST_MUL) begin
			q_q <= prod[PRD_BITS-1:HI_BITS];
		end else if (state_q == ST_COR) begin
			hi_q <= q_q + HI_BITS'(ge);
			r_q <= R_BITS'(ge ? rem - P_HI : rem);
		end
		if (state_q == ST_FIN) begin
			coef_q <= coef_d;
			lastc_q <= last_q;
		end
	end

	assign done = done_q;
	assign coefficient = coef_q;
	assign last_coefficient = lastc_q;

endmodule

// ----- tb/direct_sine_transform_top_tb.sv -----
// Self-checking testbench for the direct sine transform top level.
`timescale 1ns / 100ps

module direct_sine_transform_top_tb;

	localparam int LEN = dst_pkg::LENGTH_DEF;
	localparam int SMP_BITS = dst_pkg::SAMPLE_BITS_DEF;
	localparam int SIN_BITS = dst_pkg::SINE_BITS_DEF;
	localparam int CBITS = dst_pkg::COEF_BITS;
	localparam int TURN = 2 * (LEN + 1);
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 100;
	localparam int PHASE_WORDS = 65;

	typedef logic signed [SMP_BITS-1:0] sample_t;
	typedef logic signed [CBITS-1:0] coef_t;

	typedef struct {
		coef_t value;
		logic  last;
	} coef_word_t;

	localparam sample_t SMAX = sample_t'({1'b0, {(SMP_BITS-1){1'b1}}});
	localparam sample_t SMIN = sample_t'({1'b1, {(SMP_BITS-1){1'b0}}});

	class dst_scoreboard;
		bit         inverse;
		longint     sine_q15[TURN];
		sample_t    block_samples[$];
		coef_word_t expected_coefs[$];
		int         errors;

		function new();
			inverse = 1'b0;
			errors = 0;
			for (int m = 0; m < TURN; m++) begin
				sine_q15[m] = sine_of(m);
			end
		endfunction

		// Quadrant fold, then a Taylor series in Q30 with truncating products.
		function longint sine_of(int unsigned step);
			longint unsigned p, m, theta, term, sum_pos, sum_neg, s;
			bit neg;
			p = LEN + 1;
			m = step % (2 * p);
			neg = 1'b0;
			if (m >= p) begin
				m -= p;
				neg = 1'b1;
			end
			if (2 * m > p) m = p - m;
			theta = (longint'(dst_pkg::PI_Q30) * m + p / 2) / p;
			term = theta;
			sum_pos = theta;
			sum_neg = 0;
			for (int i = 1; i <= 7; i++) begin
				term = (term * theta) >> 30;
				term = (term * theta) >> 30;
				term = term / longint'((2 * i) * (2 * i + 1));
				if (i % 2 == 1) sum_neg += term;
				else sum_pos += term;
			end
			s = (sum_pos > sum_neg) ? sum_pos - sum_neg : 0;
			if (s > longint'(dst_pkg::ONE_Q30)) s = longint'(dst_pkg::ONE_Q30);
			s = (s + (64'd1 << (30 - SIN_BITS))) >> (31 - SIN_BITS);
			if (s > (64'd1 << (SIN_BITS - 1)) - 1) s = (64'd1 << (SIN_BITS - 1)) - 1;
			return neg ? -longint'(s) : longint'(s);
		endfunction

		// Round half away from zero, then clamp to the coefficient range.
		function coef_t scale_coef(longint acc);
			longint unsigned mag, num, den, q, r, lim_pos, lim_neg;
			bit neg;
			neg = acc < 0;
			mag = neg ? longint'(-acc) : longint'(acc);
			num = inverse ? mag * 2 : mag;
			den = longint'(inverse ? LEN + 1 : 1) << (SIN_BITS - 1);
			q = num / den;
			r = num % den;
			if (r >= den - r) q++;
			lim_pos = (64'd1 << (CBITS - 1)) - 1;
			lim_neg = 64'd1 << (CBITS - 1);
			if (neg) begin
				if (q > lim_neg) q = lim_neg;
				return coef_t'(-longint'(q));
			end
			if (q > lim_pos) q = lim_pos;
			return coef_t'(q);
		endfunction

		function void note_sample(sample_t s, logic l);
			longint acc;
			coef_word_t w;
			block_samples.push_back(s);
			if (l || block_samples.size() == LEN) begin
				for (int k = 0; k < LEN; k++) begin
					acc = 0;
					for (int n = 0; n < block_samples.size(); n++) begin
						acc += longint'(block_samples[n]) *
							sine_q15[((n + 1) * (k + 1)) % TURN];
					end
					w.value = scale_coef(acc);
					w.last = (k == LEN - 1);
					expected_coefs.push_back(w);
				end
				block_samples.delete();
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("ERROR %0t: %s", $realtime, msg);
		endtask

		task check_coefficient(coef_t c, logic l);
			coef_word_t w;
			if (expected_coefs.size() == 0) begin
				report($sformatf("coefficient %0d arrived with no word expected", c));
				return;
			end
			w = expected_coefs.pop_front();
			if (c !== w.value)
				report($sformatf("coefficient %0d, expected %0d", c, w.value));
			if (l !== w.last)
				report($sformatf("last_coefficient %b, expected %b", l, w.last));
		endtask
	endclass

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	sample_t sample = '0;
	logic    last_sample = 1'b0;
	logic    done;
	coef_t   coefficient;
	logic    last_coefficient;
	logic    config_write = 1'b0;
	logic    config_data = 1'b0;

	dst_scoreboard sb;
	int idle_cycles = 0;

	direct_sine_transform_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.sample           (sample),
		.last_sample      (last_sample),
		.done             (done),
		.coefficient      (coefficient),
		.last_coefficient (last_coefficient),
		.config_write     (config_write),
		.config_data      (config_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_coefficient(coefficient, last_coefficient);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic sample_t draw_sample();
		case ($urandom_range(0, 9))
			0: return SMAX;
			1: return SMIN;
			2: return '0;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Returns at the edge that takes the word; start stays high until the next call decides.
	task automatic send_word(sample_t s, logic l, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		last_sample <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_sample(s, l);
	endtask

	task automatic send_list(sample_t vals[$]);
		for (int i = 0; i < vals.size(); i++) begin
			send_word(vals[i], i == vals.size() - 1, $urandom_range(0, 13));
		end
	endtask

	// A full block with close_on_last low is closed by the word count alone.
	task automatic send_block(int count, bit close_on_last, bit burst);
		for (int i = 0; i < count; i++) begin
			send_word(draw_sample(), close_on_last && (i == count - 1),
				burst ? 0 : $urandom_range(0, 13));
		end
	endtask

	task automatic set_inverse(bit v);
		start <= 1'b0;
		while (sb.expected_coefs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		config_write <= 1'b1;
		config_data <= v;
		@(posedge clk);
		config_write <= 1'b0;
		sb.inverse = v;
	endtask

	initial begin
		sample_t vals[$];
		int sent;
		int count;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_inverse(1'b0);
		vals = '{SMAX};
		send_list(vals);
		vals = '{SMIN};
		send_list(vals);
		vals = '{sample_t'(0)};
		send_list(vals);
		vals = '{SMAX, SMIN};
		send_list(vals);
		vals = '{sample_t'(-1), sample_t'(1), SMIN};
		send_list(vals);
		vals = '{SMAX, SMIN, SMAX, SMIN, SMAX};
		send_list(vals);

		set_inverse(1'b1);
		vals = '{SMIN};
		send_list(vals);
		vals = '{SMAX};
		send_list(vals);
		vals = '{SMAX, SMAX, SMAX, SMAX};
		send_list(vals);

		for (int ph = 0; ph < 4; ph++) begin
			set_inverse(ph % 2 == 1);
			sent = 0;
			if (ph < 2) begin
				send_block(LEN, ph == 1, $urandom_range(0, 2) == 0);
				sent += LEN;
			end
			while (sent < PHASE_WORDS) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						send_block(LEN, 1'b0, $urandom_range(0, 2) == 0);
						sent += LEN;
					end
					3, 4: begin
						send_block(LEN, 1'b1, $urandom_range(0, 2) == 0);
						sent += LEN;
					end
					5, 6, 7: begin
						send_block(1, 1'b1, $urandom_range(0, 2) == 0);
						sent += 1;
					end
					default: begin
						count = $urandom_range(2, LEN - 1);
						send_block(count, 1'b1, $urandom_range(0, 2) == 0);
						sent += count;
					end
				endcase
			end
		end

		start <= 1'b0;
		while (sb.expected_coefs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/dst_pkg.sv
design/dst_front.sv
design/dst_queue.sv
design/dst_back.sv
design/dst_scale.sv
design/direct_sine_transform_top.sv
tb/direct_sine_transform_top_tb.sv
